/* src/rudi_pkg.sv */
// rudi_pkg: shared types and constants for the ray versus unit disc unit
// no dependencies
`timescale 1ns / 1ps

package rudi_pkg;

  // fixed formats
  localparam int FracBits  = 16;
  localparam int EntryBits = 21;
  localparam int RegBits   = 63;
  localparam int MinDenBits = 31;
  localparam int RowCnt    = 3;

  // configuration register indexes
  localparam logic [2:0] REG_ROW_X  = 3'd0;
  localparam logic [2:0] REG_ROW_Y  = 3'd1;
  localparam logic [2:0] REG_ROW_Z  = 3'd2;
  localparam logic [2:0] REG_OFFSET = 3'd3;
  localparam logic [2:0] REG_MINDEN = 3'd4;

  // reset values: identity transform, zero offset
  localparam logic [RegBits-1:0]    ROW_X_RST  = 63'd32768;
  localparam logic [RegBits-1:0]    ROW_Y_RST  = 63'd68719476736;
  localparam logic [RegBits-1:0]    ROW_Z_RST  = 63'd144115188075855872;
  localparam logic [RegBits-1:0]    OFFSET_RST = 63'd0;
  localparam logic [MinDenBits-1:0] MINDEN_RST = 31'd1;

  // per-item control traveling down the pipeline
  typedef struct packed {
    logic valid;
    logic miss;
    logic sat;
  } rudi_flags_t;

endpackage

/* src/ray_unit_disc_intersect.sv */
// ray_unit_disc_intersect: ray versus unit disc test under an affine inverse map
// depends on rudi_pkg, rudi_div, rudi_scale
`timescale 1ns / 1ps
//
// channel   direction  handshake                   payload
// s_axis    in         tvalid/tready               tdata: origin xyz, dir xyz
// m_axis    out        tvalid/tready               tdata: t, point xyz, u, v; tuser: hit
// apb       in         psel/penable/pwrite/pready  register writes and reads
//
// one ray enters per cycle while m_axis is not stalled; the pipeline is the one-bit-per-stage
// divider (CW - 1 stages) plus map, test, scale and output stages
// reset clears the valid bits and loads the identity transform
// a stall at m_axis freezes the whole pipeline; s_axis_tready follows it

module ray_unit_disc_intersect #(
  parameter int CW = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input rays
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic [((6*CW+7)/8)*8-1:0]        s_axis_tdata,
  // results
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // distance_t, point_x, point_y, point_z, disc_u, disc_v
  output logic [((4*CW+36+7)/8)*8-1:0]     m_axis_tdata,
  // hit
  output logic                             m_axis_tuser,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [5:0]                       paddr,
  input  logic [63:0]                      pwdata,
  output logic [63:0]                      prdata,
  output logic                             pready
);
  import rudi_pkg::*;

  localparam int OUT_W = ((4*CW+36+7)/8)*8;
  localparam int PW = CW + EntryBits;
  localparam int SUMW = CW + EntryBits + 2;
  localparam int MW = CW + 9;
  localparam int SIDEW = 4*MW + 6*CW;
  localparam logic signed [63:0] CMAX64 = (64'sd1 <<< (CW-1)) - 64'sd1;
  localparam logic signed [63:0] CMIN64 = -CMAX64 - 64'sd1;
  localparam logic signed [63:0] ONE64 = 64'sd65536;

  // configuration registers
  logic [RegBits-1:0]    row_q [RowCnt];
  logic [RegBits-1:0]    off_q;
  logic [MinDenBits-1:0] minden_q;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= ROW_X_RST;
      row_q[1] <= ROW_Y_RST;
      row_q[2] <= ROW_Z_RST;
      off_q    <= OFFSET_RST;
      minden_q <= MINDEN_RST;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_ROW_X:  row_q[0] <= pwdata[RegBits-1:0];
        REG_ROW_Y:  row_q[1] <= pwdata[RegBits-1:0];
        REG_ROW_Z:  row_q[2] <= pwdata[RegBits-1:0];
        REG_OFFSET: off_q    <= pwdata[RegBits-1:0];
        REG_MINDEN: minden_q <= pwdata[MinDenBits-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    unique case (paddr[5:3])
      REG_ROW_X:  prdata = 64'(row_q[0]);
      REG_ROW_Y:  prdata = 64'(row_q[1]);
      REG_ROW_Z:  prdata = 64'(row_q[2]);
      REG_OFFSET: prdata = 64'(off_q);
      REG_MINDEN: prdata = 64'(minden_q);
      default:    prdata = '0;
    endcase
  end

  // pipeline advance
  logic en, out_valid_q;
  assign en            = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_valid_q;

  // unpack input transaction
  logic signed [CW-1:0] o_in [3];
  logic signed [CW-1:0] d_in [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      o_in[j] = s_axis_tdata[j*CW +: CW];
      d_in[j] = s_axis_tdata[(j+3)*CW +: CW];
    end
  end

  // stage 1: matrix products
  logic                 v1_q;
  logic signed [PW-1:0] po_q [3][3];
  logic signed [PW-1:0] pd_q [3][3];
  logic signed [CW-1:0] o1_q [3];
  logic signed [CW-1:0] d1_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          po_q[k][j] <= PW'(signed'(row_q[k][EntryBits*j +: EntryBits])) * PW'(o_in[j]);
          pd_q[k][j] <= PW'(signed'(row_q[k][EntryBits*j +: EntryBits])) * PW'(d_in[j]);
        end
        o1_q[k] <= o_in[k];
        d1_q[k] <= d_in[k];
      end
    end
  end

  // stage 2: row sums, round half up to Q.16, add offset
  logic                   v2_q;
  logic signed [MW-1:0]   mo2_q [3];
  logic signed [MW-1:0]   md2_q [3];
  logic signed [CW-1:0]   o2_q [3];
  logic signed [CW-1:0]   d2_q [3];
  logic signed [SUMW-1:0] so [3];
  logic signed [SUMW-1:0] sd [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      so[k] = SUMW'(po_q[k][0]) + SUMW'(po_q[k][1]) + SUMW'(po_q[k][2])
              + SUMW'(16384);
      sd[k] = SUMW'(pd_q[k][0]) + SUMW'(pd_q[k][1]) + SUMW'(pd_q[k][2])
              + SUMW'(16384);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mo2_q[k] <= MW'(so[k] >>> 15)
                    + (MW'(signed'(off_q[EntryBits*k +: EntryBits])) <<< 6);
        md2_q[k] <= MW'(sd[k] >>> 15);
        o2_q[k]  <= o1_q[k];
        d2_q[k]  <= d1_q[k];
      end
    end
  end

  // stage 3: facing, behind-origin and overflow tests
  rudi_flags_t          f3_q;
  logic signed [MW-1:0] nd3_q, mo3_q [3], md3_q [2];
  logic signed [CW-1:0] o3_q [3];
  logic signed [CW-1:0] d3_q [3];
  logic signed [MW-1:0] nd;
  logic                 miss3, sat3;

  always_comb begin
    nd    = -md2_q[2];
    miss3 = (nd <= signed'(MW'(minden_q))) | mo2_q[2][MW-1];
    sat3  = (MW+CW)'(mo2_q[2]) >= ((MW+CW)'(nd) << (CW - 1 - FracBits));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f3_q <= '0;
    else if (en) f3_q <= '{valid: v2_q, miss: miss3, sat: sat3};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nd3_q <= nd;
      for (int k = 0; k < 3; k++) begin
        mo3_q[k] <= mo2_q[k];
        o3_q[k]  <= o2_q[k];
        d3_q[k]  <= d2_q[k];
      end
      md3_q[0] <= md2_q[0];
      md3_q[1] <= md2_q[1];
    end
  end

  // divider: t = mo_z * 2^16 / -md_z
  rudi_flags_t      fdv;
  logic [CW-2:0]    qdv;
  logic [SIDEW-1:0] side_in, side_dv;

  assign side_in = {mo3_q[0], mo3_q[1], md3_q[0], md3_q[1],
                    o3_q[0], o3_q[1], o3_q[2], d3_q[0], d3_q[1], d3_q[2]};

  rudi_div #(.CW(CW), .MW(MW), .SW(SIDEW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .flags_i (f3_q),
    .num_i   (mo3_q[2][MW-2:0]),
    .den_i   (nd3_q[MW-2:0]),
    .side_i  (side_in),
    .flags_o (fdv),
    .quot_o  (qdv),
    .side_o  (side_dv)
  );

  logic signed [MW-1:0] mo_dv [2];
  logic signed [MW-1:0] md_dv [2];
  logic signed [CW-1:0] o_dv [3];
  logic signed [CW-1:0] d_dv [3];
  logic [CW-2:0]        t_sel;

  assign {mo_dv[0], mo_dv[1], md_dv[0], md_dv[1],
          o_dv[0], o_dv[1], o_dv[2], d_dv[0], d_dv[1], d_dv[2]} = side_dv;
  assign t_sel = fdv.sat ? '1 : qdv;

  // products with t
  logic        sneg [5];
  logic        sbig [5];
  logic [59:0] smag [5];

  rudi_scale #(.AW(MW), .TW(CW-1)) u_scale_u (
    .clk_i(clk_i), .en_i(en), .a_i(md_dv[0]), .t_i(t_sel),
    .neg_o(sneg[0]), .big_o(sbig[0]), .mag_o(smag[0]));
  rudi_scale #(.AW(MW), .TW(CW-1)) u_scale_v (
    .clk_i(clk_i), .en_i(en), .a_i(md_dv[1]), .t_i(t_sel),
    .neg_o(sneg[1]), .big_o(sbig[1]), .mag_o(smag[1]));
  for (genvar k = 0; k < 3; k++) begin : g_pscale
    rudi_scale #(.AW(CW), .TW(CW-1)) u_scale_p (
      .clk_i(clk_i), .en_i(en), .a_i(d_dv[k]), .t_i(t_sel),
      .neg_o(sneg[2+k]), .big_o(sbig[2+k]), .mag_o(smag[2+k]));
  end

  // side data delayed alongside the scalers
  rudi_flags_t          fdl_q  [2];
  logic signed [MW-1:0] modl_q [2][2];
  logic signed [CW-1:0] odl_q  [2][3];
  logic [CW-2:0]        tdl_q  [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdl_q[0] <= '0;
      fdl_q[1] <= '0;
    end else if (en) begin
      fdl_q[0] <= fdv;
      fdl_q[1] <= fdl_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      modl_q[0][0] <= mo_dv[0];
      modl_q[0][1] <= mo_dv[1];
      modl_q[1]    <= modl_q[0];
      for (int k = 0; k < 3; k++) odl_q[0][k] <= o_dv[k];
      odl_q[1] <= odl_q[0];
      tdl_q[0] <= t_sel;
      tdl_q[1] <= tdl_q[0];
    end
  end

  // stage u: disc coordinates, range test, world point with saturation
  logic                 vu_q, missu_q;
  logic signed [17:0]   u_q, v_q;
  logic [CW-2:0]        tu_q;
  logic signed [CW-1:0] pu_q [3];
  logic signed [63:0]   u64, v64, s64;
  logic signed [63:0]   pt [3];
  logic                 missu;

  always_comb begin
    u64 = 64'(modl_q[1][0]) + (sneg[0] ? -64'(smag[0]) : 64'(smag[0]));
    v64 = 64'(modl_q[1][1]) + (sneg[1] ? -64'(smag[1]) : 64'(smag[1]));
    missu = fdl_q[1].miss | sbig[0] | sbig[1]
            | (u64 > ONE64) | (u64 < -ONE64) | (v64 > ONE64) | (v64 < -ONE64);
    s64 = '0;
    for (int k = 0; k < 3; k++) begin
      s64 = 64'(odl_q[1][k]) + (sneg[2+k] ? -64'(smag[2+k]) : 64'(smag[2+k]));
      if (sbig[2+k])       pt[k] = sneg[2+k] ? CMIN64 : CMAX64;
      else if (s64 > CMAX64) pt[k] = CMAX64;
      else if (s64 < CMIN64) pt[k] = CMIN64;
      else                 pt[k] = s64;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vu_q <= 1'b0;
    else if (en) vu_q <= fdl_q[1].valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      missu_q <= missu;
      u_q     <= u64[17:0];
      v_q     <= v64[17:0];
      tu_q    <= tdl_q[1];
      for (int k = 0; k < 3; k++) pu_q[k] <= pt[k][CW-1:0];
    end
  end

  // output stage: radius test and result register
  logic [35:0]          rad;
  logic                 hit;
  logic                 hit_q;
  logic [CW-1:0]        t_out_q;
  logic [CW-1:0]        p_out_q [3];
  logic [17:0]          u_out_q, v_out_q;

  always_comb begin
    rad = 36'(u_q * u_q) + 36'(v_q * v_q);
    hit = ~missu_q & (rad <= 36'h1_0000_0000);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= vu_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q   <= hit;
      t_out_q <= hit ? CW'(tu_q) : '0;
      for (int k = 0; k < 3; k++) p_out_q[k] <= hit ? pu_q[k] : '0;
      u_out_q <= hit ? u_q : '0;
      v_out_q <= hit ? v_q : '0;
    end
  end

  assign m_axis_tuser = hit_q;
  assign m_axis_tdata = OUT_W'({v_out_q, u_out_q, p_out_q[2], p_out_q[1], p_out_q[0],
                                t_out_q});

endmodule

/* src/rudi_div.sv */
// rudi_div: pipelined restoring divider, one quotient bit per stage
// depends on rudi_pkg
`timescale 1ns / 1ps

module rudi_div #(
  parameter int CW = 32,
  parameter int MW = 41,
  parameter int SW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  rudi_pkg::rudi_flags_t  flags_i,
  input  logic [MW-2:0]          num_i,
  input  logic [MW-2:0]          den_i,
  input  logic [SW-1:0]          side_i,
  output rudi_pkg::rudi_flags_t  flags_o,
  output logic [CW-2:0]          quot_o,
  output logic [SW-1:0]          side_o
);
  import rudi_pkg::*;

  localparam int NS = CW - 1;
  localparam int DW = MW + CW + FracBits;

  rudi_flags_t   flg_q  [NS];
  logic [DW-1:0] rem_q  [NS];
  logic [CW-2:0] quot_q [NS];
  logic [MW-2:0] den_q  [NS];
  logic [SW-1:0] side_q [NS];

  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam int Bit = NS - 1 - j;
    rudi_flags_t   flg_in;
    logic [DW-1:0] rem_in, trial, rem_d;
    logic [CW-2:0] quot_in, quot_d;
    logic [MW-2:0] den_in;
    logic [SW-1:0] side_in;
    logic          ge;

    if (j == 0) begin : g_first
      assign flg_in  = flags_i;
      assign rem_in  = DW'(num_i) << FracBits;
      assign quot_in = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign flg_in  = flg_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign quot_in = quot_q[j-1];
      assign den_in  = den_q[j-1];
      assign side_in = side_q[j-1];
    end

    // trial subtract of the shifted divisor
    always_comb begin
      trial  = DW'(den_in) << Bit;
      ge     = rem_in >= trial;
      rem_d  = ge ? rem_in - trial : rem_in;
      quot_d = quot_in;
      quot_d[Bit] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        flg_q[j] <= '0;
      end else if (en_i) begin
        flg_q[j] <= flg_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        quot_q[j] <= quot_d;
        den_q[j]  <= den_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign flags_o = flg_q[NS-1];
  assign quot_o  = quot_q[NS-1];
  assign side_o  = side_q[NS-1];

endmodule

/* src/rudi_scale.sv */
// rudi_scale: two-stage signed magnitude times t, result in Q.16 truncated
// depends on rudi_pkg
`timescale 1ns / 1ps

module rudi_scale #(
  parameter int AW = 41,
  parameter int TW = 31
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic [TW-1:0]        t_i,
  output logic                 neg_o,
  output logic                 big_o,
  output logic [59:0]          mag_o
);
  import rudi_pkg::*;

  localparam int LO = AW / 2;
  localparam int HI = AW - LO;
  localparam int PW = AW + TW;

  logic [AW-1:0]    amag;
  logic [LO+TW-1:0] pl_q;
  logic [HI+TW-1:0] ph_q;
  logic             neg1_q;
  logic [PW-1:0]    prod;

  // split partial products
  assign amag = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q   <= amag[LO-1:0] * (LO+TW)'(t_i);
      ph_q   <= amag[AW-1:LO] * (HI+TW)'(t_i);
      neg1_q <= a_i[AW-1];
    end
  end

  // recombine, drop fraction, flag magnitude of 2^60 or more
  assign prod = (PW'(ph_q) << LO) + PW'(pl_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_o <= 60'(prod >> FracBits);
      big_o <= (prod >> (60 + FracBits)) != '0;
      neg_o <= neg1_q;
    end
  end

endmodule
